// ===== design/sul_pkg.sv =====
`default_nettype none
package sul_pkg;

	localparam int unsigned DataW = 32;
	localparam int unsigned PosW = 3;
	localparam int unsigned CntOutW = 4;

	typedef enum logic [1:0] {
		OP_ADD  = 2'd0,
		OP_DEL  = 2'd1,
		OP_READ = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_ADDED    = 3'd0,
		ST_FULL     = 3'd1,
		ST_DUP      = 3'd2,
		ST_DELETED  = 3'd3,
		ST_EMPTY    = 3'd4,
		ST_NOTFOUND = 3'd5,
		ST_READOK   = 3'd6,
		ST_BADPOS   = 3'd7
	} status_t;

	// update command broadcast to every cell
	typedef struct packed {
		logic ins;
		logic del;
	} upd_t;

endpackage
`default_nettype wire

// ===== design/sorted_unique_list.sv =====
`default_nettype none
// Sorted set of up to DEPTH signed 32-bit values held in a row of cells, one
// value per cell, ascending from cell 0. A transaction is taken when start is
// high and busy is low. Each transaction runs in order: the operand is loaded,
// every cell registers its compare against the operand, and the cells shift
// (up on add, down on delete) while the result is registered. The result then
// shows for exactly one cycle with done high; the receiver cannot stall it.
// busy stays high until the result is registered, so no new transaction is
// taken while one is in progress, but one may be taken in the cycle its
// predecessor's result is shown. A read returns the entry at position (0 is
// smallest); entry_count gives the low four bits of the count after the
// transaction.
module sorted_unique_list #(
	parameter int unsigned DEPTH = 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [1:0]                    operation,
	input  wire logic signed [sul_pkg::DataW-1:0] value,
	input  wire logic [sul_pkg::PosW-1:0]      position,
	output logic                               done,
	output logic [2:0]                         status,
	output logic signed [sul_pkg::DataW-1:0]   read_value,
	output logic [sul_pkg::CntOutW-1:0]        entry_count,
	output logic                               list_full,
	output logic                               list_empty
);
	import sul_pkg::*;

	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned RD = (DEPTH < (1 << PosW)) ? DEPTH : (1 << PosW);

	logic                    busy_s1;
	logic                    busy_s2;
	op_t                     op_s1;
	op_t                     op_s2;
	logic [PosW-1:0]         pos_s1;
	logic [PosW-1:0]         pos_s2;
	logic signed [DataW-1:0] value_q;
	logic [CW-1:0]           count_q;

	logic signed [DataW-1:0] cell_entry [DEPTH];
	logic [DEPTH-1:0]        cell_valid;
	logic [DEPTH-1:0]        cell_gt;
	logic [DEPTH-1:0]        cell_eq;

	upd_t                    upd;
	status_t                 st;
	logic signed [DataW-1:0] rv;
	logic [CW-1:0]           count_d;
	logic                    full;
	logic                    empty;
	logic                    hit;
	logic                    accept;

	assign busy   = busy_s1 || busy_s2;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
			busy_s2 <= 1'b0;
			count_q <= '0;
			done    <= 1'b0;
		end else begin
			busy_s1 <= accept;
			busy_s2 <= busy_s1;
			done    <= busy_s2;
			if (busy_s2) begin
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= op_t'(operation);
			pos_s1  <= position;
			value_q <= value;
		end
		op_s2  <= op_s1;
		pos_s2 <= pos_s1;
		if (busy_s2) begin
			status      <= st;
			read_value  <= rv;
			entry_count <= CntOutW'(count_d);
			list_full   <= (count_d == CW'(DEPTH));
			list_empty  <= (count_d == '0);
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		sul_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.value       (value_q),
			.cmp_en      (busy_s1),
			.upd         (upd),
			.left_valid  ((i == 0) ? 1'b1 : cell_valid[(i == 0) ? 0 : i - 1]),
			.left_gt     ((i == 0) ? 1'b0 : cell_gt[(i == 0) ? 0 : i - 1]),
			.left_entry  (cell_entry[(i == 0) ? 0 : i - 1]),
			.right_valid ((i == DEPTH - 1) ? 1'b0 : cell_valid[(i == DEPTH - 1) ? i : i + 1]),
			.right_entry (cell_entry[(i == DEPTH - 1) ? i : i + 1]),
			.entry       (cell_entry[i]),
			.valid       (cell_valid[i]),
			.gt          (cell_gt[i]),
			.eq          (cell_eq[i])
		);
	end

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign hit   = |cell_eq;

	always_comb begin
		upd     = '0;
		st      = ST_BADPOS;
		rv      = '0;
		count_d = count_q;
		if (busy_s2) begin
			case (op_s2)
				OP_ADD: begin
					if (full) begin
						st = ST_FULL;
					end else if (hit) begin
						st = ST_DUP;
					end else begin
						st      = ST_ADDED;
						upd.ins = 1'b1;
						count_d = count_q + CW'(1);
					end
				end
				OP_DEL: begin
					if (empty) begin
						st = ST_EMPTY;
					end else if (!hit) begin
						st = ST_NOTFOUND;
					end else begin
						st      = ST_DELETED;
						upd.del = 1'b1;
						count_d = count_q - CW'(1);
					end
				end
				OP_READ: begin
					for (int i = 0; i < RD; i++) begin
						if (pos_s2 == PosW'(i) && cell_valid[i]) begin
							st = ST_READOK;
							rv = cell_entry[i];
						end
					end
				end
				default: begin
					st = ST_BADPOS;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== design/sul_cell.sv =====
`default_nettype none
module sul_cell (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic signed [sul_pkg::DataW-1:0] value,
	input  wire logic                          cmp_en,
	input  wire sul_pkg::upd_t                 upd,
	input  wire logic                          left_valid,
	input  wire logic                          left_gt,
	input  wire logic signed [sul_pkg::DataW-1:0] left_entry,
	input  wire logic                          right_valid,
	input  wire logic signed [sul_pkg::DataW-1:0] right_entry,
	output logic signed [sul_pkg::DataW-1:0]   entry,
	output logic                               valid,
	output logic                               gt,
	output logic                               eq
);
	import sul_pkg::*;

	logic signed [DataW-1:0] entry_q;
	logic                    valid_q;
	logic                    gt_q;
	logic                    eq_q;
	logic                    first_free;
	logic                    take_left;
	logic                    take_right;

	// the first empty cell receives the top of the shifted run on insert, or the new value if nothing shifts
	assign first_free = !valid_q && left_valid;
	assign take_left  = upd.ins && (gt_q || first_free);
	assign take_right = upd.del && (gt_q || eq_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			gt_q    <= 1'b0;
			eq_q    <= 1'b0;
		end else begin
			if (cmp_en) begin
				gt_q <= valid_q && (entry_q > value);
				eq_q <= valid_q && (entry_q == value);
			end
			if (take_left) begin
				valid_q <= 1'b1;
			end else if (take_right) begin
				valid_q <= right_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_left) begin
			entry_q <= left_gt ? left_entry : value;
		end else if (take_right) begin
			entry_q <= right_entry;
		end
	end

	assign entry = entry_q;
	assign valid = valid_q;
	assign gt    = gt_q;
	assign eq    = eq_q;

endmodule
`default_nettype wire

// ===== verif/sorted_unique_list_test.sv =====
`timescale 1ns / 100ps

module sorted_unique_list_test;
	import sul_pkg::*;

	localparam int unsigned Depth = 8;
	localparam int unsigned RandomItems = 1500;
	localparam int unsigned CycleLimit = 200000;
	localparam int unsigned MaxReports = 10;
	localparam logic [1:0] OpUnused = 2'd3;
	localparam logic signed [DataW-1:0] MaxVal = 32'h7fff_ffff;
	localparam logic signed [DataW-1:0] MinVal = 32'h8000_0000;

	typedef enum int {FILL_UP, DRAIN_DOWN, MIXED} mix_t;

	typedef struct packed {
		status_t                  st;
		logic signed [DataW-1:0]  rv;
		logic [CntOutW-1:0]       cnt;
		logic                     full;
		logic                     empty;
	} reply_t;

	// Mirror of the sorted set; predicts one reply per accepted transaction.
	class list_mirror;
		logic signed [DataW-1:0] slots [Depth];
		int unsigned fill;
		reply_t pending_replies [$];
		int unsigned mismatches;

		function new();
			fill = 0;
			mismatches = 0;
		endfunction

		function reply_t predict_reply(logic [1:0] op, logic signed [DataW-1:0] v,
			logic [PosW-1:0] pos);
			reply_t r;
			int unsigned place;
			int unsigned hit;
			r.st = ST_BADPOS;
			r.rv = '0;
			case (op)
				OP_ADD: begin
					if (fill >= Depth) begin
						r.st = ST_FULL;
					end else begin
						place = fill;
						hit = 0;
						for (int unsigned i = 0; i < fill; i++) begin
							if (slots[i] == v) hit = 1;
							if (place == fill && slots[i] > v) place = i;
						end
						if (hit != 0) begin
							r.st = ST_DUP;
						end else begin
							// shift the larger entries up one slot
							for (int unsigned i = fill; i > place; i--) slots[i] = slots[i-1];
							slots[place] = v;
							fill++;
							r.st = ST_ADDED;
						end
					end
				end
				OP_DEL: begin
					if (fill == 0) begin
						r.st = ST_EMPTY;
					end else begin
						hit = fill;
						for (int unsigned i = 0; i < fill; i++) begin
							if (hit == fill && slots[i] == v) hit = i;
						end
						if (hit == fill) begin
							r.st = ST_NOTFOUND;
						end else begin
							for (int unsigned i = hit; i + 1 < fill; i++) slots[i] = slots[i+1];
							fill--;
							r.st = ST_DELETED;
						end
					end
				end
				OP_READ: begin
					if (pos < fill) begin
						r.rv = slots[pos];
						r.st = ST_READOK;
					end
				end
				default: ;
			endcase
			r.cnt = fill[CntOutW-1:0];
			r.full = (fill == Depth);
			r.empty = (fill == 0);
			return r;
		endfunction

		function void take_request(logic [1:0] op, logic signed [DataW-1:0] v,
			logic [PosW-1:0] pos);
			pending_replies.push_back(predict_reply(op, v, pos));
		endfunction

		function void check_reply(reply_t got);
			reply_t want;
			if (pending_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= MaxReports)
					$display("unexpected result: st=%0d rv=%0d cnt=%0d full=%0b empty=%0b",
						got.st, got.rv, got.cnt, got.full, got.empty);
				return;
			end
			want = pending_replies.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= MaxReports)
					$display({"mismatch: expected st=%0d rv=%0d cnt=%0d full=%0b empty=%0b,",
						" got st=%0d rv=%0d cnt=%0d full=%0b empty=%0b"},
						want.st, want.rv, want.cnt, want.full, want.empty,
						got.st, got.rv, got.cnt, got.full, got.empty);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [1:0] operation;
	logic signed [DataW-1:0] value;
	logic [PosW-1:0] position;
	logic done;
	logic [2:0] status;
	logic signed [DataW-1:0] read_value;
	logic [CntOutW-1:0] entry_count;
	logic list_full;
	logic list_empty;

	list_mirror mirror = new();
	bit idling_on = 1'b1;
	int unsigned cycles = 0;

	sorted_unique_list #(
		.DEPTH(Depth)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.value(value),
		.position(position),
		.done(done),
		.status(status),
		.read_value(read_value),
		.entry_count(entry_count),
		.list_full(list_full),
		.list_empty(list_empty)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CycleLimit) begin
			$display("FAIL sorted_unique_list");
			$finish;
		end
	end

	// check the shown result before noting a new transaction at the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				mirror.check_reply(reply_t'{status_t'(status), read_value, entry_count,
					list_full, list_empty});
			if (start && !busy)
				mirror.take_request(operation, value, position);
		end
	end

	task automatic issue(input logic [1:0] op, input logic signed [DataW-1:0] v,
		input logic [PosW-1:0] pos);
		if (idling_on && $urandom_range(99) < 27) begin
			start = 1'b0;
			repeat ($urandom_range(4, 1)) @(negedge clk);
		end
		start = 1'b1;
		operation = op;
		value = v;
		position = pos;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	// hold off until every expected result has come
	task automatic wait_drained();
		start = 1'b0;
		while (mirror.pending_replies.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic signed [DataW-1:0] pick_value(int unsigned present_pct);
		int unsigned r;
		r = $urandom_range(99);
		if (mirror.fill > 0 && r < present_pct)
			return mirror.slots[$urandom_range(mirror.fill - 1)];
		r = $urandom_range(99);
		if (r < 45) return $signed($urandom_range(16)) - 8;
		if (r < 60) begin
			case ($urandom_range(3))
				0: return MinVal;
				1: return MaxVal;
				2: return MinVal + 1;
				default: return MaxVal - 1;
			endcase
		end
		return $urandom;
	endfunction

	initial begin
		mix_t mode;
		int unsigned r;
		logic [1:0] op;
		logic [PosW-1:0] pos;

		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_ADD;
		value = '0;
		position = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty list, unused code, extremes, duplicates, full list, misses
		issue(OP_READ, 0, 0);
		issue(OP_DEL, 0, 0);
		issue(OpUnused, MaxVal, 7);
		issue(OP_ADD, MaxVal, 0);
		issue(OP_ADD, MinVal, 0);
		issue(OP_ADD, 0, 0);
		issue(OP_ADD, 0, 0);
		issue(OP_READ, 0, 0);
		issue(OP_READ, 0, 1);
		issue(OP_READ, 0, 2);
		issue(OP_READ, 0, 3);
		issue(OP_ADD, -1, 0);
		issue(OP_ADD, 1, 0);
		issue(OP_ADD, -100, 0);
		issue(OP_ADD, 100, 0);
		issue(OP_ADD, 5, 0);
		issue(OP_ADD, 7, 0);
		issue(OP_ADD, 0, 0);
		issue(OP_READ, 0, 7);
		issue(OpUnused, 0, 0);
		issue(OP_DEL, 42, 0);
		issue(OP_DEL, MinVal, 0);
		issue(OP_DEL, MaxVal, 0);
		issue(OP_READ, 0, 7);
		wait_drained();

		for (int unsigned n = 0; n < RandomItems; n++) begin
			mode = mix_t'((n / 60) % 3);
			idling_on = !(n >= 600 && n < 900);
			if (n == 1100) wait_drained();
			r = $urandom_range(99);
			case (mode)
				FILL_UP:    op = (r < 70) ? OP_ADD : (r < 85) ? OP_DEL : (r < 97) ? OP_READ : OpUnused;
				DRAIN_DOWN: op = (r < 20) ? OP_ADD : (r < 75) ? OP_DEL : (r < 97) ? OP_READ : OpUnused;
				default:    op = (r < 35) ? OP_ADD : (r < 70) ? OP_DEL : (r < 97) ? OP_READ : OpUnused;
			endcase
			pos = PosW'($urandom_range(7));
			if (op == OP_READ && mirror.fill > 0 && $urandom_range(99) < 75)
				pos = PosW'($urandom_range(mirror.fill - 1));
			issue(op, pick_value(op == OP_DEL ? 60 : 15), pos);
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (mirror.mismatches == 0)
			$display("PASS sorted_unique_list");
		else
			$display("FAIL sorted_unique_list");
		$finish;
	end

endmodule
